>>> rtl/rgb_sharpen_3x3_stream_defines.svh
// Assertion macros used by the sharpen filter RTL.
`ifndef RGB_SHARPEN_3X3_STREAM_DEFINES_SVH
`define RGB_SHARPEN_3X3_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rgbs_pkg.sv
`timescale 1ns / 1ps

package rgbs_pkg;

   // Kernel gains carry this many fraction bits
   localparam int FRAC_BITS = 8;

   // Default line store depth (pixels per row)
   localparam int MAX_WIDTH_DEFAULT = 4096;

   // Smallest frame dimension
   localparam int MIN_DIM = 3;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // Register reset values
   localparam logic [12:0]        WIDTH_RESET          = 13'd4000;
   localparam logic [15:0]        HEIGHT_RESET         = 16'd3000;
   localparam logic signed [15:0] CENTER_GAIN_RESET    = 16'(5 * (1 << FRAC_BITS));
   localparam logic signed [15:0] NEIGHBOUR_GAIN_RESET = 16'(-(1 << (FRAC_BITS - 1)));

   // Register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CENTER_GAIN    = 2'd2;
   localparam logic [1:0] CSR_NEIGHBOUR_GAIN = 2'd3;

   // Item operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Largest output sample
   localparam logic [7:0] SAMPLE_MAX = 8'd255;

   typedef logic [7:0]  sample_type;
   typedef logic [23:0] pixel_type;

   typedef struct packed {
      logic       frame_end;
      sample_type blue;
      sample_type green;
      sample_type red;
   } rsp_type;

endpackage

>>> rtl/rgb_sharpen_3x3_stream.sv
`timescale 1ns / 1ps
// Channel | Direction | Ports                                        | Handshake
// req     | in        | req_operation, req_red/green/blue_in         | req_valid / req_stall
// rsp     | out       | rsp_red/green/blue_out, rsp_frame_end        | rsp_valid / rsp_stall
// csr     | in        | csr_index, csr_write_data                    | csr_write_enable
//
// One pixel or drain item is taken per clock while req_stall is low; results pass
// through the pipeline into the result queue, and the line store RAM (one read and
// one write port) sets the one-per-clock rate.
// Reset, and every register write, holds req_stall high while a bit-serial
// divider rebuilds the output row and column from the output position. The line
// stores are not cleared.
// A stalled rsp fills an eight-entry result queue; req_stall rises when eight results are owed.
`include "rgb_sharpen_3x3_stream_defines.svh"

module rgb_sharpen_3x3_stream
   import rgbs_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_frame_end,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int POS_W  = WID_W + 16;
   localparam int CNT_W  = $clog2(POS_W + 1);
   localparam int PEND_W = FIFO_CW;

   // ---------------------------------------------------------------- registers
   logic [12:0]        width_ff;
   logic [15:0]        height_ff;
   logic signed [15:0] cgain_ff;
   logic signed [15:0] ngain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         cgain_ff  <= CENTER_GAIN_RESET;
         ngain_ff  <= NEIGHBOUR_GAIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    width_ff  <= csr_write_data[12:0];
            CSR_FRAME_HEIGHT:   height_ff <= csr_write_data;
            CSR_CENTER_GAIN:    cgain_ff  <= csr_write_data;
            CSR_NEIGHBOUR_GAIN: ngain_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective frame size
   logic [WID_W-1:0] w_eff;
   logic [15:0]      h_eff;
   logic [POS_W-1:0] total_ff;

   always_comb begin
      if (width_ff < 13'(MIN_DIM)) begin
         w_eff = WID_W'(MIN_DIM);
      end else if ({1'b0, width_ff} > 14'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      h_eff = (height_ff < 16'(MIN_DIM)) ? 16'(MIN_DIM) : height_ff;
   end

   // Pixels per frame, registered product
   always_ff @(posedge clock) begin
      total_ff <= POS_W'(w_eff) * POS_W'(h_eff);
   end

   // ---------------------------------------------------------------- state
   logic [COL_W-1:0] in_col_ff,  in_col_in;
   logic [15:0]      in_row_ff,  in_row_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic [POS_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;

   // Output row/column divider
   logic [CNT_W-1:0] div_cnt_ff;
   logic [POS_W-1:0] div_num_ff, div_num_in;
   logic [WID_W-1:0] div_rem_ff, div_rem_in;
   logic [WID_W:0]   div_sh;
   logic             div_busy;

   assign div_busy = (div_cnt_ff != '0);

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      div_sh = {div_rem_ff, div_num_ff[POS_W-1]};
      if (div_sh >= {1'b0, w_eff}) begin
         div_rem_in = WID_W'(div_sh - {1'b0, w_eff});
         div_num_in = {div_num_ff[POS_W-2:0], 1'b1};
      end else begin
         div_rem_in = div_sh[WID_W-1:0];
         div_num_in = {div_num_ff[POS_W-2:0], 1'b0};
      end
   end

   // ---------------------------------------------------------------- input side
   logic [PEND_W-1:0] pending_ff;
   logic              req_accept;
   logic              drain;
   logic              complete;
   logic              item_go;
   logic              emit_s0;
   logic              border_s0;
   logic              fe_s0;
   pixel_type         pix_s0;
   logic [WID_W-1:0]  col_p1;
   logic [WID_W-1:0]  ocol_p1;

   assign req_stall  = div_busy || (pending_ff >= PEND_W'(FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign drain      = (req_operation == OP_DRAIN);
   assign complete   = (in_row_ff >= h_eff);
   assign item_go    = req_accept && !(drain && !complete);

   assign pix_s0  = complete ? '0 : {req_blue_in, req_green_in, req_red_in};
   assign emit_s0 = complete || (in_row_ff >= 16'd2) ||
                    ((in_row_ff == 16'd1) && (in_col_ff != '0));
   assign col_p1  = WID_W'(in_col_ff) + WID_W'(1);
   assign ocol_p1 = WID_W'(out_col_ff) + WID_W'(1);

   assign border_s0 = (out_row_ff == '0) ||
                      (out_row_ff >= POS_W'(h_eff - 16'd1)) ||
                      (out_col_ff == '0) ||
                      (WID_W'(out_col_ff) == (w_eff - WID_W'(1)));
   assign fe_s0 = ((out_pos_ff + POS_W'(1)) >= total_ff);

   // Raster counters for the next item
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_pos_in = out_pos_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (col_p1 >= w_eff) begin
         in_col_in = '0;
         if (in_row_ff != 16'hFFFF) begin
            in_row_in = in_row_ff + 16'd1;
         end
      end else begin
         in_col_in = COL_W'(col_p1);
      end
      if (emit_s0) begin
         if (fe_s0) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_pos_in = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            out_pos_in = out_pos_ff + POS_W'(1);
            if (ocol_p1 >= w_eff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + POS_W'(1);
            end else begin
               out_col_in = COL_W'(ocol_p1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_pos_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         div_cnt_ff <= CNT_W'(POS_W);
         div_num_ff <= '0;
         div_rem_ff <= '0;
      end else if (csr_write_enable) begin
         // on any register write, restart the row/column rebuild against the current width
         div_cnt_ff <= CNT_W'(POS_W);
         div_num_ff <= out_pos_ff;
         div_rem_ff <= '0;
      end else if (div_busy) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
         if (div_cnt_ff == CNT_W'(1)) begin
            out_row_ff <= div_num_in;
            out_col_ff <= COL_W'(div_rem_in);
         end
      end else if (item_go) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_pos_ff <= out_pos_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // ---------------------------------------------------------------- line store
   // Each word holds {upper row, middle row} for one column
   logic [47:0]      row_mem [MAX_WIDTH];
   logic [47:0]      rd_word_ff;
   logic [47:0]      wr_word_ff;
   logic [47:0]      col_word;
   logic [47:0]      wr_word;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_border_ff;
   logic             s1_fe_ff;
   logic             s1_fwd_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pixel_type        s1_pix_ff;

   // Back-to-back hit on the same column: take the word just written
   assign col_word = s1_fwd_ff ? wr_word_ff : rd_word_ff;
   assign wr_word  = {col_word[23:0], s1_pix_ff};

   always_ff @(posedge clock) begin
      if (item_go) begin
         rd_word_ff <= row_mem[in_col_ff];
      end
      if (s1_valid_ff) begin
         row_mem[s1_addr_ff] <= wr_word;
         wr_word_ff          <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= in_col_ff;
      s1_pix_ff    <= pix_s0;
      s1_emit_ff   <= emit_s0;
      s1_border_ff <= border_s0;
      s1_fe_ff     <= fe_s0;
      s1_fwd_ff    <= s1_valid_ff && (s1_addr_ff == in_col_ff);
   end

   // ---------------------------------------------------------------- window
   pixel_type win_ff [9];
   logic      s2_valid_ff;
   logic      s2_border_ff;
   logic      s2_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3+0] <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= col_word[47:24];
         win_ff[5] <= col_word[23:0];
         win_ff[8] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_border_ff <= s1_border_ff;
      s2_fe_ff     <= s1_fe_ff;
   end

   // ---------------------------------------------------------------- neighbour sums
   logic [10:0] nsum    [3];
   logic [10:0] s3_nsum_ff [3];
   sample_type  s3_ctr_ff  [3];
   pixel_type   s3_pass_ff;
   logic        s3_valid_ff;
   logic        s3_border_ff;
   logic        s3_fe_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         nsum[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
               nsum[ch] = nsum[ch] + 11'(win_ff[k][ch*8 +: 8]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         s3_nsum_ff[ch] <= nsum[ch];
         s3_ctr_ff[ch]  <= win_ff[4][ch*8 +: 8];
      end
      s3_pass_ff   <= win_ff[4];
      s3_border_ff <= s2_border_ff;
      s3_fe_ff     <= s2_fe_ff;
   end

   // ---------------------------------------------------------------- products
   logic signed [24:0] s4_pc_ff [3];
   logic signed [27:0] s4_pn_ff [3];
   pixel_type          s4_pass_ff;
   logic               s4_valid_ff;
   logic               s4_border_ff;
   logic               s4_fe_ff;

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         s4_pc_ff[ch] <= cgain_ff * $signed({1'b0, s3_ctr_ff[ch]});
         s4_pn_ff[ch] <= ngain_ff * $signed({1'b0, s3_nsum_ff[ch]});
      end
      s4_pass_ff   <= s3_pass_ff;
      s4_border_ff <= s3_border_ff;
      s4_fe_ff     <= s3_fe_ff;
   end

   // ---------------------------------------------------------------- sum, floor, clamp
   logic signed [28:0] acc    [3];
   logic signed [28:0] acc_sh [3];
   sample_type         sharp  [3];
   rsp_type            result;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch]    = s4_pc_ff[ch] + s4_pn_ff[ch];
         acc_sh[ch] = acc[ch] >>> FRAC_BITS;
         if (acc[ch][28]) begin
            sharp[ch] = '0;
         end else if (|acc_sh[ch][28:8]) begin
            sharp[ch] = SAMPLE_MAX;
         end else begin
            sharp[ch] = acc_sh[ch][7:0];
         end
      end
      result.frame_end = s4_fe_ff;
      if (s4_border_ff) begin
         result.red   = s4_pass_ff[7:0];
         result.green = s4_pass_ff[15:8];
         result.blue  = s4_pass_ff[23:16];
      end else begin
         result.red   = sharp[0];
         result.green = sharp[1];
         result.blue  = sharp[2];
      end
   end

   // ---------------------------------------------------------------- pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= item_go;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------- result queue
   rsp_type             fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff;
   logic [FIFO_AW-1:0]  rd_ptr_ff;
   logic [FIFO_CW-1:0]  fifo_cnt_ff;
   logic                rsp_xfer;
   rsp_type             rsp_head;

   assign rsp_valid     = (fifo_cnt_ff != '0);
   assign rsp_xfer      = rsp_valid && !rsp_stall;
   assign rsp_head      = fifo_mem[rd_ptr_ff];
   assign rsp_red_out   = rsp_head.red;
   assign rsp_green_out = rsp_head.green;
   assign rsp_blue_out  = rsp_head.blue;
   assign rsp_frame_end = rsp_head.frame_end;

   always_ff @(posedge clock) begin
      if (s4_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= result;
      end
   end

   // Queue pointers and the count of results owed (in flight plus queued)
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (s4_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CW'(s4_valid_ff) - FIFO_CW'(rsp_xfer);
         pending_ff  <= pending_ff + PEND_W'(item_go && emit_s0) - PEND_W'(rsp_xfer);
      end
   end

   // ---------------------------------------------------------------- assertions
   `RGBS_ASSERT_SAME(a_pending_bound, clock, reset, 1'b1, pending_ff <= PEND_W'(FIFO_DEPTH), "results owed exceed queue depth")
   `RGBS_ASSERT_SAME(a_queue_le_owed, clock, reset, 1'b1, fifo_cnt_ff <= pending_ff, "queue holds more than owed")
   `RGBS_ASSERT_NEXT(a_csr_rebuild, clock, reset, csr_write_enable, div_busy, "register write did not start rebuild")
   `RGBS_ASSERT_NEXT(a_frame_wrap, clock, reset, item_go && emit_s0 && fe_s0 && !csr_write_enable, (out_pos_ff == '0) && (in_row_ff == '0), "counters not cleared at frame end")

endmodule
